FILE: sv/assert_macros.svh
// Assertion macros used by the top RTL file of the trailer stamp block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst, prop, msg)
`define ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

FILE: sv/itsc_pkg.sv
// Types, constants and CRC function of the image trailer stamp block.
package itsc_pkg;

  localparam int unsigned LENGTH_BITS    = 24;
  localparam int unsigned SIGNATURE_BITS = 32;
  localparam int unsigned VERSION_BITS   = 16;
  localparam int unsigned ADDR_BITS      = 4;
  localparam int unsigned DATA_BITS      = 32;
  localparam int unsigned MIN_IMAGE_LENGTH = 8;

  localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = LENGTH_BITS'(MIN_IMAGE_LENGTH);
  localparam logic [15:0]            CRC_INIT     = 16'hFFFF;

  // Register index, taken from paddr[3:2]
  localparam logic [1:0] REG_IMAGE_LENGTH     = 2'd0;
  localparam logic [1:0] REG_DEVICE_SIGNATURE = 2'd1;
  localparam logic [1:0] REG_IMAGE_VERSION    = 2'd2;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] crc;
  } step_res_t;

  // Reflected CRC-16, polynomial 0x8408, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] d;
    d = b ^ crc[7:0];
    d = d ^ {d[3:0], 4'b0000};
    return {d, crc[15:8]} ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
  endfunction

endpackage

FILE: sv/itsc_step.sv
// One image byte: trailer position decode, stamp select and CRC update.
module itsc_step import itsc_pkg::*; #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic [POSITION_BITS-1:0]  pos,
  input  logic [LENGTH_BITS-1:0]    image_length,
  input  logic [SIGNATURE_BITS-1:0] device_signature,
  input  logic [VERSION_BITS-1:0]   image_version,
  input  logic [15:0]               crc,
  input  logic [7:0]                in_byte,
  output step_res_t                 res,
  output logic [POSITION_BITS-1:0]  pos_next
);

  logic [POSITION_BITS-1:0] len_mask;
  logic [POSITION_BITS-1:0] len;
  logic [POSITION_BITS:0]   pos_inc;
  logic [POSITION_BITS-1:0] back;
  logic [1:0]               sig_idx;
  logic [7:0]               stamp;

  always_comb begin
    len_mask = POSITION_BITS'(image_length);
    len      = (len_mask < POSITION_BITS'(MIN_IMAGE_LENGTH)) ?
               POSITION_BITS'(MIN_IMAGE_LENGTH) : len_mask;
    pos_inc  = {1'b0, pos} + {{POSITION_BITS{1'b0}}, 1'b1};
    // bytes left including this one; meaningful only ahead of the CRC bytes
    back     = len - pos;
    sig_idx  = 2'(4'd8 - back[3:0]);

    priority if (back >= POSITION_BITS'(5) && back <= POSITION_BITS'(8)) begin
      stamp = device_signature[sig_idx*8 +: 8];
    end else if (back == POSITION_BITS'(4)) begin
      stamp = image_version[7:0];
    end else if (back == POSITION_BITS'(3)) begin
      stamp = image_version[15:8];
    end else begin
      stamp = in_byte;
    end

    priority if (pos_inc >= {1'b0, len}) begin
      // last byte: CRC high, then restart
      res.data = crc[15:8];
      res.last = 1'b1;
      res.crc  = CRC_INIT;
      pos_next = '0;
    end else if (pos_inc + {{POSITION_BITS{1'b0}}, 1'b1} == {1'b0, len}) begin
      res.data = crc[7:0];
      res.last = 1'b0;
      res.crc  = crc;
      pos_next = pos_inc[POSITION_BITS-1:0];
    end else begin
      res.data = stamp;
      res.last = 1'b0;
      res.crc  = crc16_byte(crc, stamp);
      pos_next = pos_inc[POSITION_BITS-1:0];
    end
  end

endmodule

FILE: sv/image_trailer_stamp_crc16.sv
// Image trailer stamp: signature/version stamping and CRC-16 of a byte stream.
// The result, position and CRC are registered when a byte is accepted.
// Throughput: one byte per cycle unless in_stall (a result waits, sink stalls).
// Reset (rst, synchronous): position 0, CRC 0xFFFF, length 8, signature 0,
// version 0, output register empty.
`include "assert_macros.svh"
module image_trailer_stamp_crc16 import itsc_pkg::*; #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           in_byte,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic [7:0]           out_byte,
  output logic                 is_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  logic [LENGTH_BITS-1:0]    image_length;
  logic [SIGNATURE_BITS-1:0] device_signature;
  logic [VERSION_BITS-1:0]   image_version;
  logic [POSITION_BITS-1:0]  pos;
  logic [POSITION_BITS-1:0]  pos_next;
  logic [15:0]               crc;
  step_res_t                 res;
  logic                      in_acc;
  logic                      cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  // hold the request only while a result waits and the sink stalls
  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    unique case (paddr[3:2])
      REG_IMAGE_LENGTH:     prdata = DATA_BITS'(image_length);
      REG_DEVICE_SIGNATURE: prdata = DATA_BITS'(device_signature);
      REG_IMAGE_VERSION:    prdata = DATA_BITS'(image_version);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_length     <= LENGTH_RESET;
      device_signature <= '0;
      image_version    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_IMAGE_LENGTH:     image_length     <= pwdata[LENGTH_BITS-1:0];
        REG_DEVICE_SIGNATURE: device_signature <= pwdata[SIGNATURE_BITS-1:0];
        REG_IMAGE_VERSION:    image_version    <= pwdata[VERSION_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  itsc_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .pos              (pos),
    .image_length     (image_length),
    .device_signature (device_signature),
    .image_version    (image_version),
    .crc              (crc),
    .in_byte          (in_byte),
    .res              (res),
    .pos_next         (pos_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else if (in_acc) begin
      pos       <= pos_next;
      crc       <= res.crc;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_byte <= res.data;
      is_last  <= res.last;
    end
  end

  `ASSERT_RST(a_reset_state, clk, rst |=> (!out_valid && pos == '0 && crc == CRC_INIT), "reset state not restored")
  `ASSERT_CHK(a_last_restarts, clk, rst, (in_acc && res.last) |=> (pos == '0 && crc == CRC_INIT), "image end did not restart")
  `ASSERT_CHK(a_pos_advance, clk, rst, (in_acc && !res.last) |=> (pos == POSITION_BITS'($past(pos) + 1'b1)), "position did not advance")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of the image trailer stamp block: random images, stamping and CRC.
module tb_top import itsc_pkg::*; ;

  localparam int unsigned CLK_HALF       = 6;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned HOLD_BYTES     = 40;
  localparam int unsigned RANDOM_BYTES   = 400;
  localparam int unsigned CALM_BYTES     = 60;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam logic [1:0]  REG_UNMAPPED   = 2'd3;
  localparam logic [15:0] CRC_POLY_REFL  = 16'h8408;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } trailer_out_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic [7:0]           in_byte  = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           out_byte;
  logic                 is_last;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [ADDR_BITS-1:0] paddr     = '0;
  logic [DATA_BITS-1:0] pwdata    = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  image_trailer_stamp_crc16 dut (
    .clk, .rst, .in_byte, .in_valid, .in_stall, .out_byte, .is_last, .out_valid,
    .out_stall, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Shadow of the configuration and of the stream state
  logic [23:0] img_len   = LENGTH_RESET;
  logic [31:0] img_sig   = '0;
  logic [15:0] img_ver   = '0;
  logic [23:0] stamp_pos = '0;
  logic [15:0] stamp_crc = CRC_INIT;

  logic [7:0]   image_q[$];
  trailer_out_t trailer_out_q[$];

  logic        req_taken    = 1'b0;
  bit          idle_on      = 1'b0;
  int unsigned send_gap     = 0;
  int unsigned stall_gap    = 0;
  int unsigned hold_left    = 0;
  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count   = 0;
  int unsigned bytes_in     = 0;
  int unsigned bytes_out    = 0;
  int unsigned images_done  = 0;
  int unsigned phase_count  = 0;

  initial begin : clock_gen
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    return c;
  endfunction

  // Next output byte of the image; advance position and CRC
  function automatic trailer_out_t stamp_predict(input logic [7:0] b);
    trailer_out_t r;
    logic [24:0]  eff;
    logic [24:0]  back;
    int           shift;
    eff = (img_len < 24'd8) ? 25'd8 : {1'b0, img_len};
    r.last = 1'b0;
    if ({1'b0, stamp_pos} + 25'd1 >= eff) begin
      // final byte, also when a shorter length was set mid-image
      r.data = stamp_crc[15:8];
      r.last = 1'b1;
      stamp_pos = '0;
      stamp_crc = CRC_INIT;
    end else if ({1'b0, stamp_pos} + 25'd2 == eff) begin
      r.data = stamp_crc[7:0];
      stamp_pos = stamp_pos + 24'd1;
    end else begin
      back = eff - {1'b0, stamp_pos};
      if (back >= 25'd5 && back <= 25'd8) begin
        shift = 8 * (8 - int'(back));
        r.data = 8'(img_sig >> shift);
      end else if (back == 25'd4) begin
        r.data = img_ver[7:0];
      end else if (back == 25'd3) begin
        r.data = img_ver[15:8];
      end else begin
        r.data = b;
      end
      stamp_crc = crc_fold(stamp_crc, r.data);
      stamp_pos = stamp_pos + 24'd1;
    end
    return r;
  endfunction

  task automatic note_failure(input string what);
    if (fail_count < REPORT_LIMIT) $display("ERROR: %s", what);
    fail_count++;
  endtask

  always @(negedge clk) begin : byte_driver
    logic       v;
    logic [7:0] d;
    v = in_valid;
    d = in_byte;
    if (rst) begin
      v = 1'b0;
    end else if (!in_valid || req_taken) begin
      if (send_gap != 0) begin
        v = 1'b0;
        send_gap = send_gap - 1;
      end else if (image_q.size() == 0) begin
        v = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        v = 1'b0;
        send_gap = $urandom_range(0, 16);
      end else begin
        v = 1'b1;
        d = image_q.pop_front();
      end
    end
    // hold the request until it is taken
    in_valid <= v;
    in_byte  <= d;
  end

  always @(negedge clk) begin : stall_driver
    logic s;
    if (hold_left != 0) begin
      s = 1'b1;
      hold_left = hold_left - 1;
    end else if (holds_served != holds_asked) begin
      s = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      holds_served++;
    end else if (stall_gap != 0) begin
      s = 1'b1;
      stall_gap = stall_gap - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      s = 1'b1;
      stall_gap = $urandom_range(0, 16);
    end else begin
      s = 1'b0;
    end
    out_stall <= s;
  end

  always @(posedge clk) begin : result_monitor
    trailer_out_t want;
    if (rst) begin
      req_taken    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        trailer_out_q.push_back(stamp_predict(in_byte));
        bytes_in++;
      end
      if (out_valid && !out_stall) begin
        bytes_out++;
        if (trailer_out_q.size() == 0) begin
          note_failure($sformatf("unexpected byte %02h last %0b", out_byte, is_last));
        end else begin
          want = trailer_out_q.pop_front();
          if (want.last) images_done++;
          if (out_byte !== want.data || is_last !== want.last)
            note_failure($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                                   bytes_out, want.data, want.last, out_byte, is_last));
        end
      end
      quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ?
                      0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("Timeout: no progress for %0d cycles, %0d bytes pending",
             WATCHDOG_LIMIT, trailer_out_q.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, value, rd);
    case (idx)
      REG_IMAGE_LENGTH:     img_len = value[23:0];
      REG_DEVICE_SIGNATURE: img_sig = value;
      REG_IMAGE_VERSION:    img_ver = value[15:0];
      default: ;
    endcase
  endtask

  task automatic cfg_check_all();
    logic [31:0] rd;
    logic [31:0] want;
    for (int i = 0; i < 3; i++) begin
      apb_xfer(1'b0, 2'(i), '0, rd);
      case (2'(i))
        REG_IMAGE_LENGTH:     want = {8'h00, img_len};
        REG_DEVICE_SIGNATURE: want = img_sig;
        default:              want = {16'h0000, img_ver};
      endcase
      if (rd !== want)
        note_failure($sformatf("register %0d reads %08h, expected %08h", i, rd, want));
    end
  endtask

  // Check on the rising edge, where the driver's queue and valid are settled
  task automatic wait_drained();
    do @(posedge clk); while (image_q.size() != 0 || in_valid || trailer_out_q.size() != 0);
  endtask

  // Queue random bytes on a rising edge so the driver picks them up cleanly
  task automatic feed_bytes(input int unsigned n, input bit hold, input bit idle);
    logic [7:0] b;
    @(posedge clk);
    idle_on = idle;
    if (hold) holds_asked++;
    repeat (n) begin
      case ($urandom_range(0, 15))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      image_q.push_back(b);
    end
    phase_count++;
  endtask

  initial begin : stimulus
    logic [31:0] v;
    int unsigned eff;
    int unsigned rem;
    int unsigned n;
    int unsigned pick;
    int unsigned random_sent;
    bit          hold_done;
    random_sent = 0;
    hold_done   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: the whole image is trailer, input bytes ignored
    cfg_check_all();
    @(posedge clk);
    image_q = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA};
    wait_drained();

    // Zero length acts as eight; all-ones stamps; unmapped write ignored
    cfg_write(REG_IMAGE_LENGTH, 32'h0000_0000);
    cfg_write(REG_DEVICE_SIGNATURE, 32'hFFFF_FFFF);
    cfg_write(REG_IMAGE_VERSION, 32'hFFFF_FFFF);
    cfg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
    cfg_check_all();
    @(posedge clk);
    image_q = '{8'hFF, 8'h00, 8'h01, 8'h80, 8'hA5, 8'h5A, 8'hFF, 8'h00};
    wait_drained();

    // Widest length with upper data bits set, then cut the image short mid-stream
    cfg_write(REG_IMAGE_LENGTH, 32'hFFFF_FFFF);
    cfg_write(REG_DEVICE_SIGNATURE, 32'h1234_5678);
    cfg_write(REG_IMAGE_VERSION, 32'h0000_9ABC);
    cfg_check_all();
    @(posedge clk);
    image_q = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h0F, 8'hF0};
    wait_drained();
    cfg_write(REG_IMAGE_LENGTH, 32'd8);
    @(posedge clk);
    image_q = '{8'h3C};
    wait_drained();

    while (random_sent < RANDOM_BYTES) begin
      wait_drained();
      pick = $urandom_range(0, 9);
      if (pick < 7) v = $urandom_range(8, 40);
      else if (pick == 7) v = $urandom_range(0, 7);
      else if (pick == 8) v = $urandom_range(32'h0080_0000, 32'h00FF_FFFF);
      else v = ($urandom & 32'hFF00_0000) | $urandom_range(8, 40);
      cfg_write(REG_IMAGE_LENGTH, v);
      if ($urandom_range(0, 1) == 0) begin
        v = $urandom;
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = '1;
          default: ;
        endcase
        cfg_write(REG_DEVICE_SIGNATURE, v);
      end
      if ($urandom_range(0, 1) == 0) begin
        v = $urandom;
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = 32'h0000_FFFF;
          default: ;
        endcase
        cfg_write(REG_IMAGE_VERSION, v);
      end
      if ($urandom_range(0, 7) == 0) cfg_write(REG_UNMAPPED, $urandom);
      cfg_check_all();

      eff = (img_len < 24'd8) ? 8 : int'(img_len);
      rem = (eff > int'(stamp_pos)) ? eff - int'(stamp_pos) : 1;
      if (eff > 64) n = $urandom_range(1, 20);
      else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, rem);
      else n = rem + $urandom_range(0, 2 * eff);

      if (!hold_done && random_sent >= 100) begin
        // long receiver hold while the sender keeps offering
        hold_done = 1'b1;
        feed_bytes(HOLD_BYTES, 1'b1, 1'b0);
        random_sent += HOLD_BYTES;
      end else begin
        feed_bytes(n, 1'b0,
                   (random_sent + CALM_BYTES < RANDOM_BYTES) && ($urandom_range(0, 3) != 0));
        random_sent += n;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (trailer_out_q.size() != 0)
      note_failure($sformatf("%0d expected bytes never arrived", trailer_out_q.size()));
    $display("Streamed %0d bytes in %0d phases, %0d images closed by their CRC trailer.",
             bytes_in, phase_count, images_done);
    $display("Lengths from short to widest, stamps at both extremes, %0d failures.",
             fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
